// ----- rtl/iosp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iosp_pkg
// Shared types and constants for the interval overlap speaker select block:
// command, match and state codes, the stored entry and the running best record.
// ----------------------------------------------------------------------------
package iosp_pkg;

  localparam int TIME_W  = 40;
  localparam int LABEL_W = 8;
  localparam int TOL_W   = 24;
  localparam int OUT_W   = LABEL_W + 1;

  localparam logic [TOL_W-1:0]        TOL_RESET  = 24'd500000;
  localparam logic signed [OUT_W-1:0] LABEL_NONE = '1;

  // register index taken from the word address
  localparam logic REG_TOL = 1'b0;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_OVERLAP = 2'd1,
    KIND_NEAREST = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // one labelled interval held in a ring cell
  typedef struct packed {
    logic [TIME_W-1:0]  onset_us;
    logic [TIME_W-1:0]  end_us;
    logic [LABEL_W-1:0] label;
  } entry_t;

  // best overlap and nearest gap seen so far in a scan
  typedef struct packed {
    logic [TIME_W-1:0]  ov_us;
    logic [LABEL_W-1:0] ov_label;
    logic               have_near;
    logic [TIME_W-1:0]  gap_us;
    logic [LABEL_W-1:0] gap_label;
  } best_t;

endpackage

// ----- rtl/iosp_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iosp_cell
// One ring cell: holds one interval, loads it on append and passes it on
// to the neighbouring cell while the ring rotates.
// ----------------------------------------------------------------------------
module iosp_cell (
  input  logic             clk,
  input  logic             load_en,
  input  iosp_pkg::entry_t load_entry,
  input  logic             shift_en,
  input  iosp_pkg::entry_t shift_in,
  output iosp_pkg::entry_t entry
);

  iosp_pkg::entry_t entry_r;
  iosp_pkg::entry_t entry_nxt;

  // load wins; append and rotation never coincide
  always_comb begin
    entry_nxt = entry_r;
    if (load_en) begin
      entry_nxt = load_entry;
    end else if (shift_en) begin
      entry_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ----- rtl/iosp_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iosp_eval
// Two-stage compare unit at the head of the ring: stage one forms overlap and
// gap of the head entry against the word, stage two keeps the best of each.
// ----------------------------------------------------------------------------
module iosp_eval (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clr,
  input  logic                                vld,
  input  iosp_pkg::entry_t                    head,
  input  logic [iosp_pkg::TIME_W-1:0]         word_start_us,
  input  logic [iosp_pkg::TIME_W-1:0]         word_end_us,
  output iosp_pkg::best_t                     best
);

  localparam int TW = iosp_pkg::TIME_W;

  logic [TW-1:0]             lo_end;
  logic [TW-1:0]             hi_start;
  logic [TW:0]               ov_full;
  logic                      ov_pos;
  logic [TW-1:0]             gap;

  logic                      st1_vld_r, st1_vld_nxt;
  logic                      st1_ovp_r;
  logic [TW-1:0]             st1_ov_r;
  logic [TW-1:0]             st1_gap_r;
  logic [iosp_pkg::LABEL_W-1:0] st1_label_r;

  iosp_pkg::best_t           best_r, best_nxt;

  // stage one: overlap = min(ends) - max(starts), gap to the nearer edge
  always_comb begin
    lo_end   = (word_end_us < head.end_us) ? word_end_us : head.end_us;
    hi_start = (word_start_us > head.onset_us) ? word_start_us : head.onset_us;
    ov_full  = {1'b0, lo_end} - {1'b0, hi_start};
    ov_pos   = !ov_full[TW] && (ov_full[TW-1:0] != '0);
    if (word_end_us <= head.onset_us) begin
      gap = head.onset_us - word_end_us;
    end else if (word_start_us >= head.end_us) begin
      gap = word_start_us - head.end_us;
    end else begin
      gap = '0;
    end
  end

  assign st1_vld_nxt = vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_vld_r <= 1'b0;
    end else begin
      st1_vld_r <= st1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st1_ovp_r   <= ov_pos;
    st1_ov_r    <= ov_full[TW-1:0];
    st1_gap_r   <= gap;
    st1_label_r <= head.label;
  end

  // stage two: strict improvement only, so ties keep the earlier entry
  always_comb begin
    best_nxt = best_r;
    if (clr) begin
      best_nxt = '0;
    end else if (st1_vld_r) begin
      if (st1_ovp_r && (st1_ov_r > best_r.ov_us)) begin
        best_nxt.ov_us    = st1_ov_r;
        best_nxt.ov_label = st1_label_r;
      end
      if (!best_r.have_near || (st1_gap_r < best_r.gap_us)) begin
        best_nxt.have_near = 1'b1;
        best_nxt.gap_us    = st1_gap_r;
        best_nxt.gap_label = st1_label_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else begin
      best_r <= best_nxt;
    end
  end

  assign best = best_r;

endmodule

// ----- rtl/interval_overlap_speaker_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_overlap_speaker_select
// Labelled interval table held in a rotating ring of cells; a query rotates
// the ring once past a two-stage compare unit and picks a speaker label.
// ----------------------------------------------------------------------------
//  channel   ports                                   role
//  in_       in_valid/in_ready + command, times, label  requests: clear/append/query
//  out_      out_valid/out_ready + label, kind, status   one result per request
//  cfg       psel/penable/pwrite/paddr/pwdata/prdata   tolerance register, APB
//
//  Query: the scan steps the ring past the compare unit through every ring
//  position, a further scan step flushes the last entry into the second stage,
//  then the finish state loads the result register once that register is free.
//  Clear and append go straight to the finish state. One request is in
//  progress at a time; the next is taken only once the block is idle again.
//  Reset clears the fill count, state and result valid flag; ring cells keep no
//  reset value and are read only below the fill count.
//  A stalled result sits in the output register; the next request is taken
//  meanwhile and only its completion waits for the register to empty.
// ----------------------------------------------------------------------------
module interval_overlap_speaker_select #(
  parameter int MAX_INTERVALS = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_command,
  input  logic [iosp_pkg::TIME_W-1:0]           in_item_start_us,
  input  logic [iosp_pkg::TIME_W-1:0]           in_item_end_us,
  input  logic [iosp_pkg::LABEL_W-1:0]          in_speaker_label,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [iosp_pkg::OUT_W-1:0]     out_chosen_label,
  output logic [1:0]                            out_match_kind,
  output logic                                  out_status,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int TW = iosp_pkg::TIME_W;

  iosp_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                count_r, count_nxt;
  logic [CW-1:0]                scan_cnt_r, scan_cnt_nxt;
  logic [1:0]                   cmd_r, cmd_nxt;
  logic                         status_r, status_nxt;
  logic [TW-1:0]                word_start_r, word_end_r;
  logic [iosp_pkg::TOL_W-1:0]   tol_r, tol_nxt;

  logic                         accept;
  logic                         append_ok;
  logic                         shift_en;
  logic                         eval_vld;
  logic                         best_clr;
  logic                         fin_take;
  logic                         cfg_wr;

  iosp_pkg::entry_t             new_entry;
  iosp_pkg::entry_t             cell_q [MAX_INTERVALS];
  iosp_pkg::best_t              best;

  logic signed [iosp_pkg::OUT_W-1:0] res_label;
  logic [1:0]                        res_kind;

  logic                              out_valid_r, out_valid_nxt;
  logic signed [iosp_pkg::OUT_W-1:0] out_label_r;
  logic [1:0]                        out_kind_r;
  logic                              out_status_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == iosp_pkg::REG_TOL);
  assign tol_nxt = cfg_wr ? pwdata[iosp_pkg::TOL_W-1:0] : tol_r;
  assign prdata = (paddr[2] == iosp_pkg::REG_TOL) ?
                  {{(32 - iosp_pkg::TOL_W){1'b0}}, tol_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= iosp_pkg::TOL_RESET;
    end else begin
      tol_r <= tol_nxt;
    end
  end

  // request acceptance
  assign in_ready  = (state_r == iosp_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign append_ok = accept && (in_command == iosp_pkg::CMD_APPEND) &&
                     (count_r < CW'(MAX_INTERVALS));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iosp_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_command == iosp_pkg::CMD_QUERY) ? iosp_pkg::ST_SCAN
                                                          : iosp_pkg::ST_FINISH;
        end
      end
      iosp_pkg::ST_SCAN: begin
        if (scan_cnt_r == CW'(MAX_INTERVALS)) begin
          state_nxt = iosp_pkg::ST_FINISH;
        end
      end
      iosp_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = iosp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = iosp_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    shift_en = 1'b0;
    eval_vld = 1'b0;
    best_clr = 1'b0;
    fin_take = 1'b0;
    unique case (state_r)
      iosp_pkg::ST_IDLE: begin
        best_clr = accept;
      end
      iosp_pkg::ST_SCAN: begin
        shift_en = (scan_cnt_r < CW'(MAX_INTERVALS));
        eval_vld = (scan_cnt_r < count_r);
      end
      iosp_pkg::ST_FINISH: begin
        fin_take = !out_valid_r || out_ready;
      end
      default: begin
        shift_en = 1'b0;
      end
    endcase
  end

  // fill count, scan counter and request registers
  always_comb begin
    count_nxt    = count_r;
    scan_cnt_nxt = scan_cnt_r;
    cmd_nxt      = cmd_r;
    status_nxt   = status_r;
    if (accept) begin
      scan_cnt_nxt = '0;
      cmd_nxt      = in_command;
      status_nxt   = (in_command == iosp_pkg::CMD_APPEND) &&
                     (count_r == CW'(MAX_INTERVALS));
      if (in_command == iosp_pkg::CMD_CLEAR) begin
        count_nxt = '0;
      end else if (append_ok) begin
        count_nxt = count_r + CW'(1);
      end
    end else if (state_r == iosp_pkg::ST_SCAN) begin
      scan_cnt_nxt = scan_cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= iosp_pkg::ST_IDLE;
      count_r    <= '0;
      scan_cnt_r <= '0;
      cmd_r      <= iosp_pkg::CMD_CLEAR;
      status_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      cmd_r      <= cmd_nxt;
      status_r   <= status_nxt;
    end
  end

  // query word held for the whole scan
  always_ff @(posedge clk) begin
    if (accept) begin
      word_start_r <= in_item_start_us;
      word_end_r   <= in_item_end_us;
    end
  end

  // ring of cells; cell 0 is the head seen by the compare unit
  assign new_entry.onset_us = in_item_start_us;
  assign new_entry.end_us   = in_item_end_us;
  assign new_entry.label    = in_speaker_label;

  for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_ring
    localparam int NEXT = (k + 1) % MAX_INTERVALS;
    iosp_cell u_cell (
      .clk        (clk),
      .load_en    (append_ok && (count_r == CW'(k))),
      .load_entry (new_entry),
      .shift_en   (shift_en),
      .shift_in   (cell_q[NEXT]),
      .entry      (cell_q[k])
    );
  end

  iosp_eval u_eval (
    .clk           (clk),
    .rst_n         (rst_n),
    .clr           (best_clr),
    .vld           (eval_vld),
    .head          (cell_q[0]),
    .word_start_us (word_start_r),
    .word_end_us   (word_end_r),
    .best          (best)
  );

  // result selection: overlap first, then nearest within tolerance
  always_comb begin
    res_label = iosp_pkg::LABEL_NONE;
    res_kind  = iosp_pkg::KIND_NONE;
    if (cmd_r == iosp_pkg::CMD_QUERY) begin
      if (best.ov_us != '0) begin
        res_label = {1'b0, best.ov_label};
        res_kind  = iosp_pkg::KIND_OVERLAP;
      end else if (best.have_near &&
                   (best.gap_us <= {{(TW - iosp_pkg::TOL_W){1'b0}}, tol_r})) begin
        res_label = {1'b0, best.gap_label};
        res_kind  = iosp_pkg::KIND_NEAREST;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      out_label_r  <= res_label;
      out_kind_r   <= res_kind;
      out_status_r <= status_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_label = out_label_r;
  assign out_match_kind   = out_kind_r;
  assign out_status       = out_status_r;

endmodule

// ----- rtl/iosp_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iosp_chk
// Port-level checks for the interval overlap speaker select block, bound to
// the top level.
// ----------------------------------------------------------------------------
module iosp_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [iosp_pkg::OUT_W-1:0] out_chosen_label,
  input logic [1:0]                        out_match_kind,
  input logic                              out_status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chosen_label) &&
    $stable(out_match_kind) && $stable(out_status))
    else $error("result changed while stalled");

  // no match means no label
  a_none_label: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_match_kind == iosp_pkg::KIND_NONE) |->
    out_chosen_label == iosp_pkg::LABEL_NONE)
    else $error("label given without a match");

  // a dropped append carries no match
  a_full_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_match_kind == iosp_pkg::KIND_NONE))
    else $error("full status alongside a match");

  // a match carries a real label
  a_match_label: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_match_kind != iosp_pkg::KIND_NONE) |->
    !out_chosen_label[iosp_pkg::OUT_W-1] && !out_status)
    else $error("match without a valid label");

  // one request at a time: ready drops after an acceptance
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while one is in progress");

endmodule

bind interval_overlap_speaker_select iosp_chk u_iosp_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_chosen_label (out_chosen_label),
  .out_match_kind   (out_match_kind),
  .out_status       (out_status)
);
